@@ src/mbe_pkg.sv @@
// shared types and constants for the mandelbrot escape-time block
// no dependencies; compiled before every other file
package mbe_pkg;

	localparam int unsigned C_W           = 32;
	localparam int unsigned Z_W           = 36;
	localparam int unsigned PROD_W        = 2 * Z_W;
	localparam int unsigned CNT_W         = 16;
	localparam int unsigned FRAC_BITS_DEF = 28;
	localparam int unsigned RING_DEPTH    = 3;
	localparam int unsigned TAG_W         = $clog2(RING_DEPTH) + 1;

	typedef logic signed [C_W-1:0]    c_t;
	typedef logic signed [Z_W-1:0]    z_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [TAG_W-1:0]         tag_t;

	localparam count_t MAX_ITER_RESET = count_t'(256);

	// one point circulating in the ring
	typedef struct packed {
		logic   valid;
		logic   done;
		logic   first;
		tag_t   tag;
		count_t count;
		c_t     c_re;
		c_t     c_im;
		z_t     z_re;
		z_t     z_im;
	} slot_t;

endpackage

@@ src/mbe_ifs.sv @@
// valid/ready channel interfaces for points in and results out
// depends on mbe_pkg
interface mbe_point_if;
	import mbe_pkg::*;
	logic valid;
	logic ready;
	c_t   c_real;
	c_t   c_imag;
	modport source (output valid, output c_real, output c_imag, input ready);
	modport sink (input valid, input c_real, input c_imag, output ready);
endinterface

interface mbe_result_if;
	import mbe_pkg::*;
	logic   valid;
	logic   ready;
	count_t iter_count;
	z_t     z_real;
	z_t     z_imag;
	modport source (output valid, output iter_count, output z_real, output z_imag,
		input ready);
	modport sink (input valid, input iter_count, input z_real, input z_imag,
		output ready);
endinterface

@@ src/mbe_cmul.sv @@
// two-stage signed 36x36 multiplier built from 18-bit partial products
// depends on mbe_pkg
module mbe_cmul (
	input  logic           clk,
	input  mbe_pkg::z_t    a,
	input  mbe_pkg::z_t    b,
	output mbe_pkg::prod_t p
);
	import mbe_pkg::*;

	localparam int unsigned H_W = Z_W / 2;

	logic signed [H_W-1:0]   a_hi, b_hi;
	logic signed [H_W:0]     a_lo, b_lo;
	logic signed [2*H_W-1:0] hh_s1;
	logic signed [2*H_W:0]   hl_s1, lh_s1;
	logic signed [2*H_W+1:0] ll_s1;
	prod_t                   p_s2;

	// high halves signed, low halves zero-extended
	assign a_hi = a[Z_W-1:H_W];
	assign b_hi = b[Z_W-1:H_W];
	assign a_lo = $signed({1'b0, a[H_W-1:0]});
	assign b_lo = $signed({1'b0, b[H_W-1:0]});

	always_ff @(posedge clk) begin
		hh_s1 <= a_hi * b_hi;
		hl_s1 <= a_hi * b_lo;
		lh_s1 <= a_lo * b_hi;
		ll_s1 <= a_lo * b_lo;
	end

	always_ff @(posedge clk) begin
		p_s2 <= (prod_t'(hh_s1) <<< (2 * H_W)) + (prod_t'(hl_s1) <<< H_W)
			+ (prod_t'(lh_s1) <<< H_W) + prod_t'(ll_s1);
	end

	assign p = p_s2;

endmodule

@@ src/mbe_step.sv @@
// escape test and one z = z*z + c update for the slot leaving the products
// depends on mbe_pkg
module mbe_step #(
	parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  mbe_pkg::slot_t  slot_i,
	input  mbe_pkg::prod_t  p_rr,
	input  mbe_pkg::prod_t  p_ii,
	input  mbe_pkg::prod_t  p_ri,
	input  mbe_pkg::count_t max_iter,
	output mbe_pkg::slot_t  slot_o
);
	import mbe_pkg::*;

	localparam logic [PROD_W:0] LIMIT = (PROD_W + 1)'(1) << (FRAC_BITS + 2);

	prod_t           sr, si, sx, re_sum, im_sum;
	logic [PROD_W:0] norm;
	logic            escaped;

	always_comb begin
		sr      = p_rr >>> FRAC_BITS;
		si      = p_ii >>> FRAC_BITS;
		// cross term doubled by shifting one place less
		sx      = p_ri >>> (FRAC_BITS - 1);
		norm    = {sr[PROD_W-1], sr} + {si[PROD_W-1], si};
		escaped = norm > LIMIT;
		re_sum  = sr - si + {{(PROD_W - C_W){slot_i.c_re[C_W-1]}}, slot_i.c_re};
		im_sum  = sx + {{(PROD_W - C_W){slot_i.c_im[C_W-1]}}, slot_i.c_im};

		slot_o = slot_i;
		if (slot_i.valid && !slot_i.done) begin
			// the squares of a z that came from a pass give its norm
			if (!slot_i.first && (escaped || slot_i.count >= max_iter)) begin
				slot_o.done = 1'b1;
			end else begin
				slot_o.z_re  = re_sum[Z_W-1:0];
				slot_o.z_im  = im_sum[Z_W-1:0];
				slot_o.count = slot_i.count + count_t'(1);
				slot_o.first = 1'b0;
			end
		end
	end

endmodule

@@ src/mandelbrot_escape_iteration.sv @@
// mandelbrot escape time: three points share a three-stage ring, one pass per cycle in total
// a point circulates in the ring until it is done, then passes through the output register
// the ring holds up to three points, so new points enter while earlier ones still iterate
// results leave in arrival order; a finished point circulates until its turn
// arst_n empties the ring and output register and sets max_iter_q to 256
module mandelbrot_escape_iteration #(
	parameter int unsigned FRAC_BITS = mbe_pkg::FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  mbe_pkg::count_t      cfg_wdata,
	mbe_point_if.sink            point,
	mbe_result_if.source         result
);
	import mbe_pkg::*;

	count_t max_iter_q;
	tag_t   wr_tag_q, rd_tag_q;
	slot_t  slot_s1, slot_s2, slot_s3;
	slot_t  entry, stepped;
	prod_t  p_rr, p_ii, p_ri;
	logic   retire, slot_free;
	logic   out_valid_q;
	count_t out_count_q;
	z_t     out_z_re_q, out_z_im_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg_we) begin
			max_iter_q <= cfg_wdata;
		end
	end

	always_comb begin
		retire = slot_s3.valid && slot_s3.done && (slot_s3.tag == rd_tag_q)
			&& (!out_valid_q || result.ready);
		slot_free = !slot_s3.valid || retire;
		entry = slot_s3;
		if (slot_free) begin
			entry       = '0;
			entry.valid = point.valid;
			entry.first = 1'b1;
			entry.count = count_t'(1);
			entry.tag   = wr_tag_q;
			entry.c_re  = point.c_real;
			entry.c_im  = point.c_imag;
		end
	end

	assign point.ready = slot_free;

	mbe_cmul u_mul_rr (.clk(clk), .a(entry.z_re), .b(entry.z_re), .p(p_rr));
	mbe_cmul u_mul_ii (.clk(clk), .a(entry.z_im), .b(entry.z_im), .p(p_ii));
	mbe_cmul u_mul_ri (.clk(clk), .a(entry.z_re), .b(entry.z_im), .p(p_ri));

	mbe_step #(.FRAC_BITS(FRAC_BITS)) u_step (
		.slot_i  (slot_s2),
		.p_rr    (p_rr),
		.p_ii    (p_ii),
		.p_ri    (p_ri),
		.max_iter(max_iter_q),
		.slot_o  (stepped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_s1  <= '0;
			slot_s2  <= '0;
			slot_s3  <= '0;
			wr_tag_q <= '0;
			rd_tag_q <= '0;
		end else begin
			slot_s1 <= entry;
			slot_s2 <= slot_s1;
			slot_s3 <= stepped;
			if (point.valid && slot_free) begin
				wr_tag_q <= wr_tag_q + tag_t'(1);
			end
			if (retire) begin
				rd_tag_q <= rd_tag_q + tag_t'(1);
			end
		end
	end

	// output register parts the ring from the result channel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (retire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (retire) begin
			out_count_q <= slot_s3.count;
			out_z_re_q  <= slot_s3.z_re;
			out_z_im_q  <= slot_s3.z_im;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.iter_count = out_count_q;
	assign result.z_real     = out_z_re_q;
	assign result.z_imag     = out_z_im_q;

endmodule

@@ sim/tb.sv @@
// self-checking bench for mandelbrot_escape_iteration: directed points, then random ones
// across several iteration limits, with predicted results checked in order
// depends on mbe_pkg, mbe_ifs and the block itself
module tb;
	import mbe_pkg::*;

	localparam int unsigned FRAC = FRAC_BITS_DEF;
	localparam int          ONE  = 1 << FRAC;

	typedef struct packed {
		c_t re;
		c_t im;
	} point_t;

	typedef struct packed {
		count_t cnt;
		z_t     zr;
		z_t     zi;
	} escape_t;

	logic   clk = 1'b0;
	logic   arst_n;
	logic   cfg_we;
	count_t cfg_wdata;

	mbe_point_if  point_ch ();
	mbe_result_if result_ch ();

	mandelbrot_escape_iteration dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.point     (point_ch),
		.result    (result_ch)
	);

	point_t      point_q[$];
	escape_t     escape_q[$];
	count_t      iter_limit = MAX_ITER_RESET;
	int unsigned n_sent = 0;
	int unsigned n_errors = 0;
	int unsigned n_results = 0;
	logic        hold_arm = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// escape-time iteration at the block's widths, truncating products toward minus infinity
	function automatic escape_t predict_escape(c_t c_re, c_t c_im, count_t lim);
		prod_t       zr;
		prod_t       zi;
		prod_t       cr;
		prod_t       ci;
		prod_t       sq_r;
		prod_t       sq_i;
		prod_t       sq_x;
		prod_t       norm;
		prod_t       bound;
		z_t          nr;
		z_t          ni;
		int unsigned cnt;
		int unsigned lim_w;
		escape_t     res;
		zr    = '0;
		zi    = '0;
		cr    = prod_t'(c_re);
		ci    = prod_t'(c_im);
		bound = prod_t'(1) <<< (FRAC + 2);
		cnt   = 1;
		lim_w = 32'(lim);
		do begin
			sq_r  = (zr * zr) >>> FRAC;
			sq_i  = (zi * zi) >>> FRAC;
			sq_x  = (zr * zi) >>> (FRAC - 1);
			nr    = z_t'(sq_r - sq_i + cr);
			ni    = z_t'(sq_x + ci);
			zr    = prod_t'(nr);
			zi    = prod_t'(ni);
			cnt++;
			norm  = ((zr * zr) >>> FRAC) + ((zi * zi) >>> FRAC);
		end while (norm <= bound && cnt < lim_w);
		res.cnt = count_t'(cnt);
		res.zr  = nr;
		res.zi  = ni;
		return res;
	endfunction

	task automatic report_error(string msg);
		n_errors++;
		// keep the log short if the block is badly broken
		if (n_errors <= 200)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	// mostly points near the set, where iteration runs long; the rest anywhere
	function automatic point_t pick_point();
		point_t p;
		if ($urandom_range(3) == 0) begin
			p.re = c_t'($urandom);
			p.im = c_t'($urandom);
		end else begin
			p.re = c_t'(int'($urandom_range(805306368)) - 603979776);
			p.im = c_t'(int'($urandom_range(805306368)) - 402653184);
		end
		return p;
	endfunction

	// sender idles 33 then 66 percent, then never
	function automatic bit sender_go();
		if (n_sent < 317)
			return $urandom_range(99) >= 33;
		else if (n_sent < 634)
			return $urandom_range(99) >= 66;
		return 1'b1;
	endfunction

	// receiver idles 66 then 33 percent, then never
	function automatic bit receiver_go();
		if (n_sent < 317)
			return $urandom_range(99) >= 66;
		else if (n_sent < 634)
			return $urandom_range(99) >= 33;
		return 1'b1;
	endfunction

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			point_ch.valid  <= 1'b0;
			point_ch.c_real <= '0;
			point_ch.c_imag <= '0;
		end else begin
			if (point_ch.valid && point_ch.ready) begin
				escape_q.push_back(predict_escape(point_ch.c_real, point_ch.c_imag,
					iter_limit));
				n_sent++;
			end
			if (!point_ch.valid || point_ch.ready) begin
				if (point_q.size() != 0 && sender_go()) begin
					point_ch.valid  <= 1'b1;
					point_ch.c_real <= point_q[0].re;
					point_ch.c_imag <= point_q[0].im;
					point_q.pop_front();
				end else begin
					point_ch.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off, started once from the stimulus
	always @(posedge clk) begin
		if (hold_arm && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		escape_t exp_r;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				n_results++;
				if (escape_q.size() == 0) begin
					report_error($sformatf("result %0d with nothing expected", n_results));
				end else begin
					exp_r = escape_q.pop_front();
					if (exp_r.cnt !== result_ch.iter_count || exp_r.zr !== result_ch.z_real
							|| exp_r.zi !== result_ch.z_imag)
						report_error($sformatf(
							"result %0d: expected count %0d z (%0d, %0d), got %0d (%0d, %0d)",
							n_results, exp_r.cnt, exp_r.zr, exp_r.zi, result_ch.iter_count,
							result_ch.z_real, result_ch.z_imag));
				end
			end
			result_ch.ready <= (hold_left == 0) && receiver_go();
		end
	end

	task automatic wait_drained();
		while (point_q.size() != 0 || point_ch.valid || escape_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_limit(count_t lim);
		wait_drained();
		repeat (4) @(posedge clk);
		cfg_we     <= 1'b1;
		cfg_wdata  <= lim;
		iter_limit = lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic push_point(int re, int im);
		point_t p;
		p.re = c_t'(re);
		p.im = c_t'(im);
		point_q.push_back(p);
	endtask

	task automatic run_phase(count_t lim, int unsigned n_items);
		set_limit(lim);
		repeat (n_items) point_q.push_back(pick_point());
	endtask

	initial begin
		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_wdata        = '0;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed points under the reset limit
		push_point(0, 0);
		push_point(32'h7fffffff, 32'h7fffffff);
		push_point(32'h80000000, 32'h80000000);
		push_point(32'h7fffffff, 32'h80000000);
		push_point(32'h80000000, 32'h7fffffff);
		push_point(-2 * ONE, 0);
		push_point(2 * ONE, 0);
		push_point(ONE / 4, 0);
		push_point(0, ONE);
		push_point(-ONE, 0);
		push_point(-3 * ONE / 4, ONE / 10);
		push_point(3 * ONE / 10, ONE / 2);
		push_point(1, -1);
		push_point(-1, -1);
		push_point(4 * ONE, 0);
		push_point(0, -2 * ONE);

		// a zero limit still does one z update
		run_phase(count_t'(0), 40);
		run_phase(count_t'(1), 40);
		run_phase(count_t'(2), 50);
		run_phase(count_t'(3), 60);
		hold_arm = 1'b1;
		run_phase(count_t'(17), 200);
		run_phase(count_t'(64), 250);
		run_phase(count_t'(100), 150);
		run_phase(MAX_ITER_RESET, 140);
		run_phase(count_t'(1000), 4);
		set_limit(count_t'(65535));
		push_point(0, 0);
		point_q.push_back(pick_point());

		wait_drained();
		repeat (20) @(posedge clk);
		if (n_errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10000000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
